// ----- rtl/rdll_pkg.sv -----
// ----------------------------------------------------------------------------
// rdll_pkg
// Shared types and constants of the least-loaded request dispatcher.
// ----------------------------------------------------------------------------
package rdll_pkg;

   localparam int MAX_WORKERS = 8;
   localparam int WIDX_BITS   = 3;
   localparam int SCORE_BITS  = 16;
   localparam int WCNT_BITS   = 4;
   localparam int FIFO_DEPTH  = 2;

   typedef enum logic [1:0] {
      CMD_SUBMIT  = 2'd0,
      CMD_STATUS  = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_RUNNING = 2'd2,
      ST_DOWN        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_QUEUE_LIMIT  = 2'd0,
      CSR_QUEUE_DOWN   = 2'd1,
      CSR_WORKER_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        has_key;
      logic [63:0] key_hash;
      logic        has_preferred;
      logic [7:0]  preferred_index;
      logic [2:0]  target_worker;
      logic        running_flag;
      logic        healthy_flag;
      logic        accepting_flag;
      logic [15:0] load_value;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  status;
      logic [2:0]  chosen_worker;
      logic [15:0] unsent_now;
      logic [31:0] accepted_total;
      logic [31:0] rejected_total;
   } rsp_type;

endpackage

// ----- rtl/rdll_if.sv -----
// ----------------------------------------------------------------------------
// rdll_req_if / rdll_rsp_if / rdll_csr_if
// Valid/ready channels of the dispatcher.
// ----------------------------------------------------------------------------
interface rdll_req_if;
   import rdll_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rdll_rsp_if;
   import rdll_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rdll_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rdll_fifo.sv -----
// ----------------------------------------------------------------------------
// rdll_fifo
// Two-entry request queue between the request input and the back part.
// ----------------------------------------------------------------------------
module rdll_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rdll_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rdll_pkg::req_type out_data
);
   import rdll_pkg::*;

   req_type    mem_ff [FIFO_DEPTH];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'(FIFO_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- rtl/rdll_back.sv -----
// ----------------------------------------------------------------------------
// rdll_back
// Sequencer that applies status updates and releases and routes submits.
// ----------------------------------------------------------------------------
module rdll_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rdll_pkg::req_type in_data,
   input  logic [15:0]       queue_limit,
   input  logic              queue_when_down,
   input  logic [3:0]        num_workers,
   output logic              out_valid,
   input  logic              out_ready,
   output rdll_pkg::rsp_type out_data
);
   import rdll_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_KEY, S_SCAN, S_FALL, S_OUT
   } state_type;

   state_type              state_ff;
   logic [MAX_WORKERS-1:0] run_ff, hlt_ff, acc_ff;
   logic [SCORE_BITS-1:0]  load_ff [MAX_WORKERS];
   logic [15:0]            unsent_ff;
   logic [WIDX_BITS-1:0]   rr_ff;
   logic [31:0]            acount_ff, rcount_ff;
   logic [WCNT_BITS-1:0]   n_ff;
   logic [63:0]            hash_ff;
   logic [3:0]             rem_ff;
   logic [5:0]             step_ff;
   logic [WIDX_BITS-1:0]   idx_ff, best_ff, pick_ff;
   logic [WCNT_BITS-1:0]   i_ff;
   logic                   found_ff;
   logic [SCORE_BITS-1:0]  bscore_ff;
   status_type             st_ff;
   rsp_type                rsp_ff;
   logic                   ovalid_ff;

   logic                   ovalid_in;
   logic                   out_fire;
   logic [WCNT_BITS-1:0]   n_act;
   logic [WIDX_BITS-1:0]   idx_nx;
   logic [WIDX_BITS-1:0]   pref;
   logic [3:0]             rem_sh;
   status_type             st_fin;

   function automatic status_type chk(input logic r, input logic h, input logic q);
      status_type s;
      s = ST_OK;
      if (!r) s = ST_NOT_RUNNING;
      else if (!h && !q) s = ST_DOWN;
      return s;
   endfunction

   // scan start: round-robin pointer reduced modulo the worker count
   function automatic logic [2:0] rr_mod(input logic [2:0] r, input logic [3:0] n);
      logic [2:0] m;
      case (n)
         4'd1: m = 3'd0;
         4'd2: m = {2'd0, r[0]};
         4'd3: m = (r >= 3'd6) ? r - 3'd6 : ((r >= 3'd3) ? r - 3'd3 : r);
         4'd4: m = {1'b0, r[1:0]};
         4'd5: m = (r >= 3'd5) ? r - 3'd5 : r;
         4'd6: m = (r >= 3'd6) ? r - 3'd6 : r;
         4'd7: m = (r == 3'd7) ? 3'd0 : r;
         default: m = r;
      endcase
      return m;
   endfunction

   assign n_act     = (num_workers > 4'(MAX_WORKERS)) ? 4'(MAX_WORKERS) : num_workers;
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_data  = rsp_ff;
   assign idx_nx    = ({1'b0, idx_ff} + 4'd1 == n_ff) ? 3'd0 : idx_ff + 3'd1;
   assign pref      = in_data.preferred_index[2:0];
   assign rem_sh    = {rem_ff[2:0], hash_ff[63]};
   assign st_fin    = (st_ff == ST_OK && !acc_ff[pick_ff]) ? ST_FULL : st_ff;
   assign out_fire  = (state_ff == S_OUT) && (!ovalid_ff || out_ready);
   assign ovalid_in = out_fire || (ovalid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         run_ff    <= '0;
         hlt_ff    <= '0;
         acc_ff    <= '0;
         for (int k = 0; k < MAX_WORKERS; k++) load_ff[k] <= '0;
         unsent_ff <= '0;
         rr_ff     <= '0;
         acount_ff <= '0;
         rcount_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  case (cmd_type'(in_data.cmd))
                     CMD_STATUS: begin
                        run_ff[in_data.target_worker]  <= in_data.running_flag;
                        hlt_ff[in_data.target_worker]  <= in_data.healthy_flag;
                        acc_ff[in_data.target_worker]  <= in_data.accepting_flag;
                        load_ff[in_data.target_worker] <= in_data.load_value;
                     end
                     CMD_RELEASE: begin
                        if (unsent_ff != 16'd0) unsent_ff <= unsent_ff - 16'd1;
                     end
                     CMD_SUBMIT: begin
                        if (unsent_ff >= queue_limit) begin
                           st_ff    <= ST_FULL;
                           state_ff <= S_OUT;
                        end else begin
                           unsent_ff <= unsent_ff + 16'd1;
                           n_ff      <= n_act;
                           if (in_data.has_preferred &&
                               (in_data.preferred_index < {4'd0, n_act})) begin
                              pick_ff  <= pref;
                              st_ff    <= chk(run_ff[pref], hlt_ff[pref], queue_when_down);
                              state_ff <= S_OUT;
                           end else if (n_act == 4'd0) begin
                              st_ff    <= ST_NOT_RUNNING;
                              state_ff <= S_OUT;
                           end else if (in_data.has_key) begin
                              hash_ff  <= in_data.key_hash;
                              rem_ff   <= '0;
                              step_ff  <= '0;
                              state_ff <= S_MOD;
                           end else begin
                              idx_ff   <= rr_mod(rr_ff, n_act);
                              rr_ff    <= rr_ff + 3'd1;
                              i_ff     <= '0;
                              found_ff <= 1'b0;
                              state_ff <= S_SCAN;
                           end
                        end
                     end
                     CMD_NONE: ;
                     default: ;
                  endcase
               end
            end
            S_MOD: begin
               // one dividend bit per cycle, restoring remainder
               rem_ff   <= (rem_sh >= n_ff) ? rem_sh - n_ff : rem_sh;
               hash_ff  <= {hash_ff[62:0], 1'b0};
               step_ff  <= step_ff + 6'd1;
               if (step_ff == 6'd63) state_ff <= S_KEY;
            end
            S_KEY: begin
               pick_ff  <= rem_ff[2:0];
               st_ff    <= chk(run_ff[rem_ff[2:0]], hlt_ff[rem_ff[2:0]], queue_when_down);
               state_ff <= S_OUT;
            end
            S_SCAN: begin
               if (i_ff == n_ff) begin
                  if (found_ff) begin
                     st_ff    <= ST_OK;
                     pick_ff  <= best_ff;
                     state_ff <= S_OUT;
                  end else if (queue_when_down) begin
                     i_ff     <= '0;
                     state_ff <= S_FALL;
                  end else begin
                     st_ff    <= ST_DOWN;
                     state_ff <= S_OUT;
                  end
               end else begin
                  if (run_ff[idx_ff] && hlt_ff[idx_ff] &&
                      (!found_ff || load_ff[idx_ff] < bscore_ff)) begin
                     found_ff  <= 1'b1;
                     best_ff   <= idx_ff;
                     bscore_ff <= load_ff[idx_ff];
                  end
                  idx_ff <= idx_nx;
                  i_ff   <= i_ff + 4'd1;
               end
            end
            S_FALL: begin
               // take the first running worker in scan order
               if (i_ff == n_ff) begin
                  st_ff    <= ST_DOWN;
                  state_ff <= S_OUT;
               end else if (run_ff[idx_ff]) begin
                  st_ff    <= ST_OK;
                  pick_ff  <= idx_ff;
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_nx;
                  i_ff   <= i_ff + 4'd1;
               end
            end
            S_OUT: begin
               if (out_fire) begin
                  if (st_fin == ST_OK) begin
                     acount_ff             <= acount_ff + 32'd1;
                     rsp_ff.accepted       <= 1'b1;
                     rsp_ff.status         <= ST_OK;
                     rsp_ff.chosen_worker  <= pick_ff;
                     rsp_ff.unsent_now     <= unsent_ff;
                     rsp_ff.accepted_total <= acount_ff + 32'd1;
                     rsp_ff.rejected_total <= rcount_ff;
                  end else begin
                     rcount_ff             <= rcount_ff + 32'd1;
                     rsp_ff.accepted       <= 1'b0;
                     rsp_ff.status         <= st_fin;
                     rsp_ff.chosen_worker  <= 3'd0;
                     // queue-full rejection holds no slot; others release theirs
                     if (st_ff == ST_FULL) begin
                        rsp_ff.unsent_now <= unsent_ff;
                     end else begin
                        rsp_ff.unsent_now <= unsent_ff - 16'd1;
                        unsent_ff         <= unsent_ff - 16'd1;
                     end
                     rsp_ff.accepted_total <= acount_ff;
                     rsp_ff.rejected_total <= rcount_ff + 32'd1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/rdll_front.sv -----
// ----------------------------------------------------------------------------
// rdll_front
// Configuration registers of the dispatcher.
// ----------------------------------------------------------------------------
module rdll_front (
   input  logic       clock,
   input  logic       reset,
   rdll_csr_if.sink   csr,
   output logic [15:0] queue_limit,
   output logic        queue_when_down,
   output logic [3:0]  num_workers
);
   import rdll_pkg::*;

   logic [15:0] qlim_ff;
   logic        qdown_ff;
   logic [3:0]  wcnt_ff;

   assign csr.ready       = 1'b1;
   assign queue_limit     = qlim_ff;
   assign queue_when_down = qdown_ff;
   assign num_workers     = wcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qlim_ff  <= 16'd1024;
         qdown_ff <= 1'b0;
         wcnt_ff  <= 4'd4;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_QUEUE_LIMIT:  qlim_ff  <= csr.data;
            CSR_QUEUE_DOWN:   qdown_ff <= csr.data[0];
            CSR_WORKER_COUNT: wcnt_ff  <= csr.data[3:0];
            default: ;
         endcase
      end
   end
endmodule

// ----- rtl/request_dispatch_least_loaded.sv -----
// ----------------------------------------------------------------------------
// request_dispatch_least_loaded
// Least-loaded dispatcher with key-hash affinity over up to eight workers.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are handled one at a time by a
// sequencer; results leave through one output register, so the sequencer
// keeps working while one result waits and stalls only when its next result
// is ready. A status or release is applied straight from the idle state;
// a submit rejected on the queue limit, on no workers, or sent to its
// preferred worker goes straight to the output state; a scan submit looks
// for the least-loaded healthy running worker and, if none is found and down
// workers may be queued to, takes the first running worker; a keyed submit
// first forms its 64-bit hash modulo the worker count, one bit per cycle.
module request_dispatch_least_loaded (
   input logic     clock,
   input logic     reset,
   rdll_req_if.sink   req,
   rdll_rsp_if.source rsp,
   rdll_csr_if.sink   csr
);
   import rdll_pkg::*;

   logic    q_valid, q_ready;
   req_type q_data;
   logic [15:0] queue_limit;
   logic        queue_when_down;
   logic [3:0]  num_workers;

   rdll_front u_front (
      .clock, .reset, .csr,
      .queue_limit, .queue_when_down, .num_workers
   );

   rdll_fifo u_fifo (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   rdll_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .queue_limit, .queue_when_down, .num_workers,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );
endmodule

// ----- dv/rdll_tb_if.sv -----
// ----------------------------------------------------------------------------
// rdll_tb_if
// Testbench-side note: the dispatcher's channel interfaces come from the RTL
// file; this file holds the shared test constants of the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package rdll_tb_pkg;
   localparam int MAX_SHOWN   = 10;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 80;
endpackage

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the least-loaded dispatcher: submits, status updates and releases
// are driven with random gaps; an in-bench dispatch predictor keeps its own
// worker table and counters and every result transaction is compared with
// the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
   import rdll_pkg::*;
   import rdll_tb_pkg::*;

   logic clock;
   logic reset;
   rdll_req_if req ();
   rdll_rsp_if rsp ();
   rdll_csr_if csr ();

   request_dispatch_least_loaded uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // predictor state
   logic [15:0] lim;
   logic        down_ok;
   logic [3:0]  wcnt;
   logic [7:0]  run_b, hlt_b, acc_b;
   logic [15:0] load_q [8];
   logic [15:0] unsent;
   logic [2:0]  rr_ptr;
   logic [31:0] n_acc, n_rej;

   rsp_type     dispatch_queue [$];
   int          errors = 0;
   int          cycles = 0;
   bit          rsp_gaps;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [1:0] direct_status(input int w);
      if (!run_b[w]) return ST_NOT_RUNNING;
      if (!hlt_b[w] && !down_ok) return ST_DOWN;
      return ST_OK;
   endfunction

   function automatic void predict_dispatch(input req_type r);
      int n, idx, pick, best;
      logic [1:0] st;
      logic [15:0] best_load;
      bit found;
      rsp_type e;
      case (cmd_type'(r.cmd))
         CMD_STATUS: begin
            run_b[r.target_worker] = r.running_flag;
            hlt_b[r.target_worker] = r.healthy_flag;
            acc_b[r.target_worker] = r.accepting_flag;
            load_q[r.target_worker] = r.load_value;
            return;
         end
         CMD_RELEASE: begin
            if (unsent != 16'd0) unsent = unsent - 16'd1;
            return;
         end
         CMD_NONE: return;
         default: ;
      endcase
      pick = 0;
      st = ST_OK;
      if (unsent >= lim) begin
         st = ST_FULL;
      end else begin
         unsent = unsent + 16'd1;
         n = (wcnt > MAX_WORKERS) ? MAX_WORKERS : int'(wcnt);
         if (r.has_preferred && r.preferred_index < n) begin
            pick = int'(r.preferred_index);
            st = direct_status(pick);
         end else if (n == 0) begin
            st = ST_NOT_RUNNING;
         end else if (r.has_key) begin
            pick = int'(r.key_hash % 64'(n));
            st = direct_status(pick);
         end else begin
            found = 0;
            best = 0;
            best_load = '0;
            for (int i = 0; i < n; i++) begin
               idx = (rr_ptr + i) % n;
               if (run_b[idx] && hlt_b[idx] && (!found || load_q[idx] < best_load)) begin
                  found = 1;
                  best = idx;
                  best_load = load_q[idx];
               end
            end
            if (!found && down_ok) begin
               for (int i = n - 1; i >= 0; i--) begin
                  idx = (rr_ptr + i) % n;
                  if (run_b[idx]) begin
                     found = 1;
                     best = idx;
                  end
               end
            end
            rr_ptr = rr_ptr + 3'd1;
            pick = best;
            st = found ? ST_OK : ST_DOWN;
         end
         if (st == ST_OK && !acc_b[pick]) st = ST_FULL;
         if (st != ST_OK) unsent = unsent - 16'd1;
      end
      if (st == ST_OK) n_acc = n_acc + 32'd1;
      else n_rej = n_rej + 32'd1;
      e.accepted = (st == ST_OK);
      e.status = st;
      e.chosen_worker = (st == ST_OK) ? 3'(pick) : 3'd0;
      e.unsent_now = unsent;
      e.accepted_total = n_acc;
      e.rejected_total = n_rej;
      dispatch_queue = {dispatch_queue, e};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                  input logic [63:0] act_v);
      errors++;
      if (errors <= MAX_SHOWN)
         $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type e, a;
      if (!reset && rsp.valid && rsp.ready) begin
         a = rsp.payload;
         if (dispatch_queue.size() == 0) begin
            report_mismatch("unexpected result", 64'd0, 64'(a.unsent_now));
         end else begin
            e = dispatch_queue.pop_front();
            if (a.accepted !== e.accepted)
               report_mismatch("accepted", 64'(e.accepted), 64'(a.accepted));
            if (a.status !== e.status)
               report_mismatch("status", 64'(e.status), 64'(a.status));
            if (a.chosen_worker !== e.chosen_worker)
               report_mismatch("chosen_worker", 64'(e.chosen_worker),
                               64'(a.chosen_worker));
            if (a.unsent_now !== e.unsent_now)
               report_mismatch("unsent_now", 64'(e.unsent_now), 64'(a.unsent_now));
            if (a.accepted_total !== e.accepted_total)
               report_mismatch("accepted_total", 64'(e.accepted_total),
                               64'(a.accepted_total));
            if (a.rejected_total !== e.rejected_total)
               report_mismatch("rejected_total", 64'(e.rejected_total),
                               64'(a.rejected_total));
         end
      end
   end

   // result-side stall
   initial begin
      int w;
      rsp.ready = 1'b0;
      @(negedge clock);
      rsp.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            w = rsp_gaps ? $urandom_range(0, 7) : 0;
            @(negedge clock);
            if (w != 0) begin
               rsp.ready <= 1'b0;
               repeat (w) @(negedge clock);
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_item(input req_type r);
      int w;
      w = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
         req.valid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req.payload <= r;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      predict_dispatch(r);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type i, input logic [15:0] d);
      @(negedge clock);
      csr.index <= i;
      csr.data <= d;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      case (i)
         CSR_QUEUE_LIMIT:  lim = d;
         CSR_QUEUE_DOWN:   down_ok = d[0];
         default:          wcnt = d[3:0];
      endcase
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (dispatch_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic req_type make_submit(input bit k, input logic [63:0] h,
                                           input bit p, input logic [7:0] pi);
      req_type r;
      r = '0;
      r.cmd = CMD_SUBMIT;
      r.has_key = k;
      r.key_hash = h;
      r.has_preferred = p;
      r.preferred_index = pi;
      return r;
   endfunction

   function automatic req_type make_status(input logic [2:0] t, input bit ru,
                                           input bit he, input bit ac,
                                           input logic [15:0] ld);
      req_type r;
      r = '0;
      r.cmd = CMD_STATUS;
      r.target_worker = t;
      r.running_flag = ru;
      r.healthy_flag = he;
      r.accepting_flag = ac;
      r.load_value = ld;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int sel;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      sel = $urandom_range(0, 99);
      if (sel < 55) r.cmd = CMD_SUBMIT;
      else if (sel < 80) r.cmd = CMD_STATUS;
      else if (sel < 97) r.cmd = CMD_RELEASE;
      else r.cmd = CMD_NONE;
      if ($urandom_range(0, 2) != 0) r.preferred_index = 8'($urandom_range(0, 9));
      if ($urandom_range(0, 2) == 0) r.has_key = 1'b0;
      if ($urandom_range(0, 3) != 0) r.running_flag = 1'b1;
      if ($urandom_range(0, 3) != 0) r.healthy_flag = 1'b1;
      if ($urandom_range(0, 3) != 0) r.accepting_flag = 1'b1;
      if ($urandom_range(0, 1) != 0) r.load_value = 16'($urandom_range(0, 7));
      return r;
   endfunction

   task automatic test_directed();
      send_item(make_submit(1'b0, 64'd0, 1'b0, 8'd0));
      send_item(make_status(3'd0, 1'b1, 1'b1, 1'b1, 16'd5));
      send_item(make_status(3'd1, 1'b1, 1'b1, 1'b1, 16'd2));
      send_item(make_status(3'd2, 1'b1, 1'b0, 1'b1, 16'd0));
      send_item(make_status(3'd3, 1'b0, 1'b1, 1'b1, 16'hFFFF));
      send_item(make_status(3'd7, 1'b1, 1'b1, 1'b0, 16'd1));
      send_item(make_submit(1'b0, 64'd0, 1'b0, 8'd0));
      send_item(make_submit(1'b0, 64'd0, 1'b0, 8'd0));
      send_item(make_submit(1'b0, 64'd0, 1'b1, 8'd2));
      send_item(make_submit(1'b0, 64'd0, 1'b1, 8'd3));
      send_item(make_submit(1'b0, 64'd0, 1'b1, 8'hFF));
      send_item(make_submit(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0));
      send_item(make_submit(1'b1, 64'd0, 1'b0, 8'd0));
      send_item(make_status(3'd1, 1'b1, 1'b1, 1'b0, 16'd0));
      send_item(make_submit(1'b1, 64'd5, 1'b0, 8'd0));
      for (int i = 0; i < 4; i++) send_item('{cmd: CMD_RELEASE, default: '0});
      send_item('{cmd: CMD_NONE, default: '1});
      wait_idle();
      write_reg(CSR_QUEUE_DOWN, 16'd1);
      send_item(make_submit(1'b0, 64'd0, 1'b1, 8'd2));
      send_item(make_submit(1'b1, 64'd2, 1'b0, 8'd0));
      wait_idle();
   endtask

   task automatic test_config_extremes();
      write_reg(CSR_WORKER_COUNT, 16'd0);
      send_item(make_submit(1'b0, 64'd0, 1'b0, 8'd0));
      send_item(make_submit(1'b1, 64'd9, 1'b1, 8'd0));
      wait_idle();
      write_reg(CSR_WORKER_COUNT, 16'd15);
      write_reg(CSR_QUEUE_LIMIT, 16'd0);
      send_item(make_submit(1'b0, 64'd0, 1'b0, 8'd0));
      wait_idle();
      write_reg(CSR_QUEUE_LIMIT, 16'd2);
      for (int i = 0; i < 5; i++) send_item(make_submit(1'b0, 64'd0, 1'b1, 8'd0));
      wait_idle();
      write_reg(CSR_QUEUE_LIMIT, 16'hFFFF);
      write_reg(CSR_QUEUE_DOWN, 16'd0);
   endtask

   task automatic test_random(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r = random_item();
         send_item(r);
      end
      wait_idle();
   endtask

   initial begin
      rsp_gaps = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.payload = '0;
      csr.valid = 1'b0;
      csr.index = CSR_QUEUE_LIMIT;
      csr.data = '0;
      lim = 16'd1024;
      down_ok = 1'b0;
      wcnt = 4'd4;
      run_b = '0;
      hlt_b = '0;
      acc_b = '0;
      for (int i = 0; i < 8; i++) load_q[i] = '0;
      unsent = '0;
      rr_ptr = '0;
      n_acc = '0;
      n_rej = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      rsp_gaps = 1;
      test_random(300);
      write_reg(CSR_WORKER_COUNT, 16'd3);
      write_reg(CSR_QUEUE_DOWN, 16'd1);
      write_reg(CSR_QUEUE_LIMIT, 16'd4);
      test_random(300);
      write_reg(CSR_WORKER_COUNT, 16'd8);
      write_reg(CSR_QUEUE_LIMIT, 16'd20);
      rsp_gaps = 0;
      test_random(150);
      rsp_gaps = 1;
      write_reg(CSR_WORKER_COUNT, 16'd1);
      write_reg(CSR_QUEUE_DOWN, 16'd0);
      test_random(150);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
